// ----- hdl/calibration_row_best_match_assert.svh -----
// assertion macros used by the calibration row table checker
`ifndef CALIBRATION_ROW_BEST_MATCH_ASSERT_SVH
`define CALIBRATION_ROW_BEST_MATCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CRBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CRBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/crbm_pkg.sv -----
// types, constants and helper functions of the calibration row table
package crbm_pkg;

    // field widths
    localparam int ANT_W  = 24;
    localparam int FREQ_W = 27;
    localparam int TIME_W = 33;
    localparam int BAND_W = 4;

    // band table
    localparam int BAND_COUNT = 12;
    localparam int NAME_CHARS = 3;
    localparam int EDGE_COUNT = 13;
    localparam logic [FREQ_W-1:0] BAND_EDGE_KHZ [EDGE_COUNT] = '{
        27'd0,        27'd450000,   27'd900000,   27'd1550000,  27'd2000000,
        27'd4000000,  27'd6000000,  27'd10000000, 27'd18000000, 27'd26000000,
        27'd40000000, 27'd70000000, 27'd100000000
    };

    // input item layout in tdata, lowest bit first
    localparam int IN_DATA_W = 152;
    localparam int ANT_LSB   = 0;
    localparam int SX_BIT    = 24;
    localparam int FREQ_LSB  = 25;
    localparam int QT_LSB    = 52;
    localparam int VF_LSB    = 85;
    localparam int VU_LSB    = 118;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_INVAL = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BAND  = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_CLEAR,
        OP_NO_BAND,
        OP_SCAN,
        OP_SCAN_END,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  band_ok;
        logic  scan_done;
        logic  out_free;
    } t_dp_status;

    // one stored row, antenna in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] row_end;
        logic [TIME_W-1:0] row_start;
        logic [FREQ_W-1:0] freq;
        logic [BAND_W-1:0] band;
        logic [ANT_W-1:0]  ant;
    } t_row;

    typedef struct packed {
        logic valid;
        logic sx;
    } t_flags;

    typedef struct packed {
        logic              ok;
        logic [BAND_W-1:0] band;
    } t_band_class;

    // band lookup: band i covers edge[i] < f < edge[i+1]
    function automatic t_band_class classify_band(input logic [FREQ_W-1:0] f);
        t_band_class res;
        res = '0;
        for (int i = 0; i < EDGE_COUNT - 1; i++) begin
            if (i < BAND_COUNT && f > BAND_EDGE_KHZ[i] && f < BAND_EDGE_KHZ[i+1]) begin
                res.ok   = 1'b1;
                res.band = BAND_W'(i);
            end
        end
        return res;
    endfunction

    // fold lower case letters to upper case in the low name bytes
    function automatic logic [ANT_W-1:0] fold_code(input logic [ANT_W-1:0] code);
        logic [ANT_W-1:0] res;
        logic [7:0]       c;
        res = code;
        for (int k = 0; k < ANT_W / 8; k++) begin
            c = code[8*k +: 8];
            if (k < NAME_CHARS && c >= 8'h61 && c <= 8'h7a) begin
                res[8*k +: 8] = c - 8'h20;
            end
        end
        return res;
    endfunction

endpackage

// ----- hdl/crbm_ram.sv -----
// generic single write port ram with registered read
module crbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/crbm_ctrl.sv -----
// controller: sequences load, clear, scan and result hand-off for one item
module crbm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crbm_pkg::t_dp_status i_dp_status,
    output crbm_pkg::t_dp_cmd   o_dp_cmd
);
    import crbm_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_dp_cmd.op = OP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.op = OP_LATCH;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_dp_status.mode)
                    MODE_LOAD: begin
                        o_dp_cmd.op = OP_LOAD;
                        n_state     = S_FINISH;
                    end
                    MODE_INVAL: begin
                        n_state = S_SCAN;
                    end
                    MODE_QUERY: begin
                        if (i_dp_status.band_ok) begin
                            n_state = S_SCAN;
                        end else begin
                            o_dp_cmd.op = OP_NO_BAND;
                            n_state     = S_FINISH;
                        end
                    end
                    default: begin
                        o_dp_cmd.op = OP_CLEAR;
                        n_state     = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_dp_status.scan_done) begin
                    o_dp_cmd.op = OP_SCAN_END;
                    n_state     = S_FINISH;
                end else begin
                    o_dp_cmd.op = OP_SCAN;
                end
            end
            S_FINISH: begin
                if (i_dp_status.out_free) begin
                    o_dp_cmd.op = OP_EMIT;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/crbm_dp.sv -----
// datapath: row memories, scan pipeline, best-row tracking and result register
module crbm_dp #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crbm_pkg::t_dp_cmd             i_cmd,
    output crbm_pkg::t_dp_status          o_status,
    input  logic [crbm_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic [1:0]                    i_in_user,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [((((TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1)
                   + $clog2(TABLE_ROWS + 1) + 7) / 8) * 8 - 1:0] o_out_data,
    output logic [1:0]                    o_out_user
);
    import crbm_pkg::*;

    localparam int AW    = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CW    = $clog2(TABLE_ROWS + 1);
    localparam int OUT_W = ((AW + CW + 7) / 8) * 8;
    localparam int ROW_W = $bits(t_row);
    localparam int FLG_W = $bits(t_flags);

    // latched item
    t_mode             r_mode;
    logic [ANT_W-1:0]  r_ant;
    logic [ANT_W-1:0]  r_key;
    logic              r_sx;
    logic [FREQ_W-1:0] r_freq;
    logic [TIME_W-1:0] r_qt;
    logic [TIME_W-1:0] r_vf;
    logic [TIME_W-1:0] r_vu;
    logic [BAND_W-1:0] r_band;
    logic              r_band_ok;

    // table fill and scan address
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_addr;

    // scan pipeline
    logic              r_p1_valid;
    logic [AW-1:0]     r_p1_addr;
    logic              r_p2_valid;
    logic              r_p2_hit;
    logic              r_p2_db;
    logic [FREQ_W-1:0] r_p2_df;
    logic [AW-1:0]     r_p2_addr;
    logic              r_p2_sx;

    // best row so far
    logic              r_have;
    logic [AW-1:0]     r_best_idx;
    logic              r_best_db;
    logic [FREQ_W-1:0] r_best_df;

    // result and output register
    t_status           r_res_status;
    logic [AW-1:0]     r_res_index;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [AW-1:0]     r_out_index;
    logic [CW-1:0]     r_out_count;

    t_band_class       w_class;
    logic              w_load_ok;
    logic              w_issue;
    logic              w_row_wr;
    logic              w_flag_wr;
    logic [AW-1:0]     w_flag_addr;
    t_flags            w_flag_wdata;
    logic [ROW_W-1:0]  w_row_rdata;
    logic [FLG_W-1:0]  w_flag_rdata;
    t_row              w_row;
    t_flags            w_flags;
    t_row              w_row_wdata;
    logic [BAND_W-1:0] w_diff;
    logic [FREQ_W-1:0] w_df;
    logic              w_qual;
    logic              w_match;
    logic              w_better;

    // band of the incoming frequency
    assign w_class = classify_band(i_in_data[FREQ_LSB +: FREQ_W]);

    // load and scan control decode
    assign w_load_ok = (r_count < CW'(TABLE_ROWS)) && r_band_ok;
    assign w_issue   = (i_cmd.op == OP_SCAN) && (r_addr < r_count);
    assign w_row_wr  = (i_cmd.op == OP_LOAD) && w_load_ok;

    // flag memory write: set on load, clear valid on an invalidate hit
    always_comb begin
        w_flag_wr    = w_row_wr || (r_p2_valid && r_p2_hit && r_mode == MODE_INVAL);
        w_flag_addr  = w_row_wr ? r_count[AW-1:0] : r_p2_addr;
        w_flag_wdata = w_row_wr ? {1'b1, r_sx} : {1'b0, r_p2_sx};
    end

    assign w_row_wdata = {r_vu, r_vf, r_freq, r_band, r_ant};

    crbm_ram #(
        .WIDTH(ROW_W),
        .DEPTH(TABLE_ROWS)
    ) u_row_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_row_wr),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(w_row_wdata),
        .i_rd_en  (w_issue),
        .i_rd_addr(r_addr[AW-1:0]),
        .o_rd_data(w_row_rdata)
    );

    crbm_ram #(
        .WIDTH(FLG_W),
        .DEPTH(TABLE_ROWS)
    ) u_flag_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_flag_wr),
        .i_wr_addr(w_flag_addr),
        .i_wr_data(w_flag_wdata),
        .i_rd_en  (w_issue),
        .i_rd_addr(r_addr[AW-1:0]),
        .o_rd_data(w_flag_rdata)
    );

    // row compare on memory read data
    always_comb begin
        w_row   = t_row'(w_row_rdata);
        w_flags = t_flags'(w_flag_rdata);
        w_diff  = (r_band >= w_row.band) ? r_band - w_row.band : w_row.band - r_band;
        w_df    = (r_freq >= w_row.freq) ? r_freq - w_row.freq : w_row.freq - r_freq;
        w_qual  = w_flags.valid && (w_row.ant == r_ant) && (w_flags.sx == r_sx)
                  && (r_qt > w_row.row_start) && (r_qt <= w_row.row_end)
                  && (w_diff <= BAND_W'(1));
        w_match = w_flags.valid && (fold_code(w_row.ant) == r_key);
    end

    // ranking against the best row so far
    assign w_better = !r_have || (r_p2_db < r_best_db)
                      || (r_p2_db == r_best_db && r_p2_df < r_best_df);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_issue;
            r_p2_valid <= r_p1_valid;
            case (i_cmd.op)
                OP_LATCH: begin
                    r_addr <= '0;
                    r_have <= 1'b0;
                end
                OP_LOAD: begin
                    if (w_load_ok) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                OP_CLEAR: begin
                    r_count <= '0;
                end
                OP_SCAN: begin
                    if (w_issue) begin
                        r_addr <= r_addr + CW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (r_p2_valid && r_p2_hit && w_better) begin
                r_have <= 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // item capture
        if (i_cmd.op == OP_LATCH) begin
            r_mode    <= t_mode'(i_in_user);
            r_ant     <= i_in_data[ANT_LSB +: ANT_W];
            r_key     <= fold_code(i_in_data[ANT_LSB +: ANT_W]);
            r_sx      <= i_in_data[SX_BIT];
            r_freq    <= i_in_data[FREQ_LSB +: FREQ_W];
            r_qt      <= i_in_data[QT_LSB +: TIME_W];
            r_vf      <= i_in_data[VF_LSB +: TIME_W];
            r_vu      <= i_in_data[VU_LSB +: TIME_W];
            r_band    <= w_class.band;
            r_band_ok <= w_class.ok;
        end
        // compare stage
        r_p1_addr <= r_addr[AW-1:0];
        r_p2_hit  <= (r_mode == MODE_INVAL) ? w_match : w_qual;
        r_p2_db   <= w_diff[0];
        r_p2_df   <= w_df;
        r_p2_addr <= r_p1_addr;
        r_p2_sx   <= w_flags.sx;
        // best row update
        if (r_p2_valid && r_p2_hit && w_better) begin
            r_best_idx <= r_p2_addr;
            r_best_db  <= r_p2_db;
            r_best_df  <= r_p2_df;
        end
        // result of the current item
        case (i_cmd.op)
            OP_LOAD: begin
                if (r_count >= CW'(TABLE_ROWS)) begin
                    r_res_status <= ST_FULL;
                    r_res_index  <= '0;
                end else if (!r_band_ok) begin
                    r_res_status <= ST_NO_BAND;
                    r_res_index  <= '0;
                end else begin
                    r_res_status <= ST_OK;
                    r_res_index  <= r_count[AW-1:0];
                end
            end
            OP_CLEAR: begin
                r_res_status <= ST_OK;
                r_res_index  <= '0;
            end
            OP_NO_BAND: begin
                r_res_status <= ST_NO_BAND;
                r_res_index  <= '0;
            end
            OP_SCAN_END: begin
                if (r_mode == MODE_QUERY && !r_have) begin
                    r_res_status <= ST_NO_MATCH;
                    r_res_index  <= '0;
                end else begin
                    r_res_status <= ST_OK;
                    r_res_index  <= (r_mode == MODE_QUERY) ? r_best_idx : '0;
                end
            end
            default: begin
            end
        endcase
        // output register load
        if (i_cmd.op == OP_EMIT) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_count  <= r_count;
        end
    end

    // status to the controller
    always_comb begin
        o_status.mode      = r_mode;
        o_status.band_ok   = r_band_ok;
        o_status.scan_done = !(r_addr < r_count) && !r_p1_valid && !r_p2_valid;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_W'({r_out_count, r_out_index});
    assign o_out_user  = r_out_status;

endmodule

// ----- hdl/calibration_row_best_match.sv -----
// top level of the calibration row table with best-match lookup
//
// Input items arrive on the s_axis channel; tuser carries the operation
// (load row, invalidate antenna, query best row, clear table) and tdata the
// antenna code, dual-band flag, frequency and the three time values.
// One result item per input item leaves on the m_axis channel: tuser holds
// the status, tdata the row index and the number of rows held.
// The block works on one item at a time. A load or clear completes
// without a scan. An invalidate or query reads every held row
// once through the row memory read port, one row a cycle, followed by
// the compare pipeline and the best-row update. A query whose frequency
// lies outside all bands skips the scan. The result sits in an output
// register; the next item is accepted while it waits, and a stalled
// receiver only holds the block once the following result is ready. Reset
// empties the table (no rows held) and drops any pending result; the row
// memories are not cleared.
module calibration_row_best_match #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // antenna_code, sx_mode, freq_khz, query_time, valid_from, valid_until
    input  logic [crbm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // row_index, rows_held
    output logic [((((TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1)
                   + $clog2(TABLE_ROWS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);
    import crbm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    crbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_dp_status(w_status),
        .o_dp_cmd   (w_cmd)
    );

    // table and scan datapath
    crbm_dp #(
        .TABLE_ROWS(TABLE_ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_user (m_axis_tuser)
    );

endmodule

// ----- hdl/crbm_check.sv -----
// port-level checks of the calibration row table and their binding
`include "calibration_row_best_match_assert.svh"

module crbm_check #(
    parameter int TABLE_ROWS = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [((((TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1)
                  + $clog2(TABLE_ROWS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import crbm_pkg::*;

    localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CW = $clog2(TABLE_ROWS + 1);

    logic [AW-1:0] w_index;
    logic [CW-1:0] w_held;

    assign w_index = m_axis_tdata[AW-1:0];
    assign w_held  = m_axis_tdata[AW +: CW];

    // stalled result item holds
    `CRBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // one item at a time: no accept right after an accept
    `CRBM_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

    // failed operations report index zero
    `CRBM_ASSERT_NOW(a_fail_index, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, w_index == '0, "nonzero index on a failed operation")

    // table full only when every row is held
    `CRBM_ASSERT_NOW(a_full_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_FULL, w_held == CW'(TABLE_ROWS), "table full reported below capacity")

endmodule

bind calibration_row_best_match crbm_check #(
    .TABLE_ROWS(TABLE_ROWS)
) u_crbm_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
